FILE: rtl/dbd_pkg.sv
// Shared constants and types for the delta bit-pack block decoder.
// No dependencies; imported by delta_bitpack_block_decoder_top.
package dbd_pkg;

    localparam int VALUE_W       = 64;
    localparam int MAX_WIDTH_DEF = 64;
    localparam int BYTE_W        = 8;

    typedef logic [4:0] t_hcnt;

    // header byte counts at which a header field is complete
    localparam t_hcnt HB_COUNT = 5'd4;
    localparam t_hcnt HB_WIDTH = 5'd8;
    localparam t_hcnt HB_MIN   = 5'd16;
    localparam t_hcnt HB_FIRST = 5'd24;

    // bit positions in the result tuser
    localparam int USR_FIRST = 0;
    localparam int USR_LAST  = 1;
    localparam int USR_ERR   = 2;
    localparam int USR_W     = 3;

    typedef logic [USR_W-1:0] t_usr;

endpackage

FILE: rtl/delta_bitpack_block_decoder_top.sv
// Delta bit-pack block decoder: 24-byte header, then bit-serial delta extraction.
// Depends on dbd_pkg.
//
//  channel  | dir | tdata (low bit up)   | tuser (low bit up)                        | tlast
//  s_axis   | in  | byte_value[7:0]      | kind                                      | -
//  m_axis   | out | value[63:0]          | first_of_block, last_of_block, width_error | last_result
//
// Header beats and drain ticks are taken only when the output register can load. A payload
// beat is accepted first; then the byte shift register feeds its 8 bits into the delta register,
// one bit per cycle unless stalled; a delta completes on its last bit and loads one value.
// A full output register stalls the bit shifting only on the bit that completes a delta.
// Synchronous active-low reset returns to the header phase with no result pending.
module delta_bitpack_block_decoder_top #(
    parameter int MAX_WIDTH = dbd_pkg::MAX_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [dbd_pkg::BYTE_W-1:0]  s_axis_tdata,   // byte_value
    input  logic [0:0]                  s_axis_tuser,   // kind
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [dbd_pkg::VALUE_W-1:0] m_axis_tdata,   // value
    output logic [dbd_pkg::USR_W-1:0]   m_axis_tuser,   // first, last_of_block, width_error
    output logic                        m_axis_tlast    // last_result
);
    import dbd_pkg::*;

    localparam int W_BITS = $clog2(MAX_WIDTH + 2);

    typedef enum logic [1:0] {
        S_HDR,
        S_PAY_IDLE,
        S_PAY_SHIFT,
        S_DRAIN
    } t_state;

    t_state                r_state, n_state;
    t_hcnt                 r_hcnt, n_hcnt;
    logic [VALUE_W-1:0]    r_hshift, n_hshift;
    logic [31:0]           r_vleft, n_vleft;
    logic [W_BITS-1:0]     r_width, n_width;
    logic [VALUE_W-1:0]    r_min, n_min;
    logic [VALUE_W-1:0]    r_run, n_run;
    logic [MAX_WIDTH-1:0]  r_d, n_d;
    logic [W_BITS-1:0]     r_cnt, n_cnt;
    logic [BYTE_W-1:0]     r_byte, n_byte;
    logic [2:0]            r_bitidx, n_bitidx;
    logic                  r_ov, n_ov;
    logic [VALUE_W-1:0]    r_odata, n_odata;
    t_usr                  r_ouser, n_ouser;
    logic                  r_olast, n_olast;

    logic                  can_load;
    logic                  accept;
    logic                  kind;
    logic [VALUE_W-1:0]    hs_new;
    t_hcnt                 hcnt_new;
    logic [MAX_WIDTH-1:0]  d_new;
    logic [W_BITS-1:0]     cnt_new;
    logic [31:0]           vleft_dec;
    logic [2:0]            bits_after;

    assign can_load      = !r_ov || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign kind          = s_axis_tuser[0];
    assign hs_new        = {r_hshift[VALUE_W-BYTE_W-1:0], s_axis_tdata};
    assign hcnt_new      = r_hcnt + 5'd1;
    assign d_new         = (r_d << 1) | MAX_WIDTH'(r_byte[BYTE_W-1]);
    assign cnt_new       = r_cnt + W_BITS'(1);
    assign vleft_dec     = r_vleft - 32'd1;
    assign bits_after    = 3'd7 - r_bitidx;

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

    always_comb begin
        case (r_state)
            S_HDR:       s_axis_tready = can_load;
            S_PAY_IDLE:  s_axis_tready = 1'b1;
            S_PAY_SHIFT: s_axis_tready = 1'b0;
            S_DRAIN:     s_axis_tready = can_load;
            default:     s_axis_tready = 1'b0;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_hcnt   = r_hcnt;
        n_hshift = r_hshift;
        n_vleft  = r_vleft;
        n_width  = r_width;
        n_min    = r_min;
        n_run    = r_run;
        n_d      = r_d;
        n_cnt    = r_cnt;
        n_byte   = r_byte;
        n_bitidx = r_bitidx;
        n_ov     = r_ov && !m_axis_tready;
        n_odata  = r_odata;
        n_ouser  = r_ouser;
        n_olast  = r_olast;

        case (r_state)
            S_HDR: begin
                if (accept && !kind) begin
                    n_hshift = hs_new;
                    n_hcnt   = hcnt_new;
                    if (hcnt_new == HB_COUNT) begin
                        n_vleft = hs_new[31:0];
                    end else if (hcnt_new == HB_WIDTH) begin
                        n_width = (hs_new[31:0] > 32'(MAX_WIDTH)) ? W_BITS'(MAX_WIDTH + 1)
                                                                  : hs_new[W_BITS-1:0];
                    end else if (hcnt_new == HB_MIN) begin
                        n_min = hs_new;
                    end else if (hcnt_new == HB_FIRST) begin
                        n_run   = hs_new;
                        n_hcnt  = '0;
                        n_d     = '0;
                        n_cnt   = '0;
                        n_ov    = 1'b1;
                        n_olast = 1'b1;
                        if (r_width > W_BITS'(MAX_WIDTH)) begin
                            n_odata            = '0;
                            n_ouser            = '0;
                            n_ouser[USR_ERR]   = 1'b1;
                            n_ouser[USR_LAST]  = 1'b1;
                        end else begin
                            n_odata            = hs_new;
                            n_ouser            = '0;
                            n_ouser[USR_FIRST] = 1'b1;
                            n_ouser[USR_LAST]  = (r_vleft == 32'd0);
                            if (r_vleft == 32'd0) begin
                                n_state = S_HDR;
                            end else if (r_width == '0) begin
                                n_state = S_DRAIN;
                            end else begin
                                n_state = S_PAY_IDLE;
                            end
                        end
                    end
                end
            end
            S_PAY_IDLE: begin
                if (accept && !kind) begin
                    n_byte   = s_axis_tdata;
                    n_bitidx = '0;
                    n_state  = S_PAY_SHIFT;
                end
            end
            S_PAY_SHIFT: begin
                if (cnt_new != r_width || can_load) begin
                    n_byte   = r_byte << 1;
                    n_bitidx = r_bitidx + 3'd1;
                    if (r_bitidx == 3'd7) begin
                        n_state = S_PAY_IDLE;
                    end
                    if (cnt_new == r_width) begin
                        n_run              = r_run + r_min + VALUE_W'(d_new);
                        n_vleft            = vleft_dec;
                        n_d                = '0;
                        n_cnt              = '0;
                        n_ov               = 1'b1;
                        n_odata            = r_run + r_min + VALUE_W'(d_new);
                        n_ouser            = '0;
                        n_ouser[USR_LAST]  = (vleft_dec == 32'd0);
                        n_olast            = (vleft_dec == 32'd0)
                                          || (8'(r_width) > 8'(bits_after));
                        if (vleft_dec == 32'd0) begin
                            n_state = S_HDR;
                        end
                    end else begin
                        n_d   = d_new;
                        n_cnt = cnt_new;
                    end
                end
            end
            S_DRAIN: begin
                if (accept && kind) begin
                    n_run             = r_run + r_min;
                    n_vleft           = vleft_dec;
                    n_ov              = 1'b1;
                    n_odata           = r_run + r_min;
                    n_ouser           = '0;
                    n_ouser[USR_LAST] = (vleft_dec == 32'd0);
                    n_olast           = 1'b1;
                    if (vleft_dec == 32'd0) begin
                        n_state = S_HDR;
                    end
                end
            end
            default: begin
                n_state = S_HDR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HDR;
            r_hcnt  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hcnt  <= n_hcnt;
            r_ov    <= n_ov;
        end
        r_hshift <= n_hshift;
        r_vleft  <= n_vleft;
        r_width  <= n_width;
        r_min    <= n_min;
        r_run    <= n_run;
        r_d      <= n_d;
        r_cnt    <= n_cnt;
        r_byte   <= n_byte;
        r_bitidx <= n_bitidx;
        r_odata  <= n_odata;
        r_ouser  <= n_ouser;
        r_olast  <= n_olast;
    end

`ifndef ASSERT_OFF
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[USR_ERR]) |->
        (m_axis_tdata == '0 && m_axis_tuser[USR_LAST] && !m_axis_tuser[USR_FIRST]
         && m_axis_tlast))
        else $error("width error beat malformed");

    a_first_tlast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[USR_FIRST]) |-> m_axis_tlast)
        else $error("first value not marked as last result of its beat");

    a_vleft_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAY_IDLE || r_state == S_PAY_SHIFT || r_state == S_DRAIN)
        |-> (r_vleft != 32'd0))
        else $error("payload or drain phase with no values left");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAY_IDLE || r_state == S_PAY_SHIFT)
        |-> (r_cnt < r_width && r_width <= W_BITS'(MAX_WIDTH)))
        else $error("delta bit count out of range");
`endif

endmodule

FILE: tb/tb.sv
// Self-checking bench for delta_bitpack_block_decoder_top: byte blocks in, decoded values out.
// Depends on dbd_pkg and delta_bitpack_block_decoder_top; an internal predictor supplies
// the expected values.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dbd_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int RAND_ITEMS = 370;
    localparam int IDLE_PCT   = 28;

    typedef enum logic [1:0] {PH_HEADER, PH_PAYLOAD, PH_DRAIN} t_dec_phase;
    typedef enum bit {K_BYTE = 1'b0, K_DRAIN = 1'b1} t_beat_kind;

    typedef struct {
        bit         hold;
        t_beat_kind kind;
        bit [7:0]   data;
    } t_stream_beat;

    typedef struct packed {
        logic [63:0] value;
        logic        blk_first;
        logic        blk_last;
        logic        wid_err;
        logic        beat_last;
    } t_dec_val;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [BYTE_W-1:0]    s_axis_tdata = '0;   // byte_value
    logic [0:0]           s_axis_tuser = '0;   // kind
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [VALUE_W-1:0]   m_axis_tdata;        // value
    logic [USR_W-1:0]     m_axis_tuser;        // first_of_block, last_of_block, width_error
    logic                 m_axis_tlast;        // last_result

    delta_bitpack_block_decoder_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    t_stream_beat pending_beats[$];
    t_dec_val     expected_vals[$];
    t_stream_beat cur_beat;
    bit           beat_busy;
    int           n_in_acc;
    int           n_fail;
    int           idle_cycles;
    int           n_rand;
    logic         steady;

    assign steady = (n_in_acc >= 200) && (n_in_acc < 320);

    // decoder state
    t_dec_phase   ph;
    t_hcnt        hcnt;
    logic [31:0]  vals_left;
    int           dw;
    logic [63:0]  min_d;
    logic [63:0]  run_val;
    logic [71:0]  acc;
    int           nbits;
    logic [63:0]  hshift;

    task automatic decode_beat(input t_beat_kind kind, input logic [7:0] b);
        t_dec_val    outs[$];
        logic [63:0] d;
        logic [31:0] w32;
        int          s;
        if (kind == K_DRAIN) begin
            if (ph == PH_DRAIN) begin
                run_val += min_d;
                vals_left--;
                outs.push_back('{run_val, 1'b0, vals_left == 0, 1'b0, 1'b0});
                if (vals_left == 0) ph = PH_HEADER;
            end
        end else if (ph == PH_PAYLOAD) begin
            acc = {acc[63:0], b};
            nbits += 8;
            while (vals_left != 0 && nbits >= dw && outs.size() < 8) begin
                s = nbits - dw;
                d = 64'(acc >> s);
                if (dw < 64) d &= (64'd1 << dw) - 64'd1;
                nbits = s;
                run_val += min_d + d;
                vals_left--;
                outs.push_back('{run_val, 1'b0, vals_left == 0, 1'b0, 1'b0});
            end
            if (vals_left == 0) begin
                ph = PH_HEADER;
                acc = '0;
                nbits = 0;
            end
        end else if (ph != PH_DRAIN) begin
            hshift = {hshift[55:0], b};
            hcnt++;
            case (hcnt)
                HB_COUNT: begin
                    vals_left = hshift[31:0];
                end
                HB_WIDTH: begin
                    w32 = hshift[31:0];
                    dw = (w32 > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF + 1 : int'(w32);
                end
                HB_MIN: begin
                    min_d = hshift;
                end
                HB_FIRST: begin
                    run_val = hshift;
                    hcnt = '0;
                    acc = '0;
                    nbits = 0;
                    if (dw > MAX_WIDTH_DEF) begin
                        outs.push_back('{64'd0, 1'b0, 1'b1, 1'b1, 1'b0});
                        ph = PH_HEADER;
                    end else begin
                        outs.push_back('{run_val, 1'b1, vals_left == 0, 1'b0, 1'b0});
                        if (vals_left == 0) ph = PH_HEADER;
                        else if (dw == 0) ph = PH_DRAIN;
                        else ph = PH_PAYLOAD;
                    end
                end
                default: ;
            endcase
        end
        if (outs.size() > 0) outs[outs.size()-1].beat_last = 1'b1;
        foreach (outs[i]) expected_vals.push_back(outs[i]);
    endtask

    task automatic push_beat(input t_beat_kind kind, input logic [7:0] b, input bit counted);
        pending_beats.push_back('{1'b0, kind, b});
        if (counted) n_rand++;
    endtask

    task automatic push_hold();
        pending_beats.push_back('{1'b1, K_BYTE, 8'h00});
    endtask

    function automatic logic [63:0] pick64();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h7fff_ffff_ffff_ffff;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // header, then packed deltas or drain ticks; noisy adds beats the decoder ignores
    task automatic add_block(input logic [31:0] cnt, input logic [31:0] wraw,
                             input logic [63:0] mind, input logic [63:0] fval, input bit noisy);
        logic [191:0] hdr;
        logic [63:0]  d;
        logic [7:0]   b;
        bit           bitq[$];
        int           w;
        hdr = {cnt, wraw, mind, fval};
        for (int i = 0; i < 24; i++) begin
            if (noisy && $urandom_range(9) == 0) push_beat(K_DRAIN, 8'($urandom), 1'b0);
            push_beat(K_BYTE, hdr[191-8*i -: 8], 1'b1);
        end
        if (wraw > MAX_WIDTH_DEF || cnt == 0) return;
        w = int'(wraw);
        if (w == 0) begin
            for (int k = 0; k < int'(cnt); k++) begin
                if (noisy && $urandom_range(3) == 0) push_beat(K_BYTE, 8'($urandom), 1'b0);
                push_beat(K_DRAIN, 8'($urandom), 1'b1);
            end
            return;
        end
        for (int k = 0; k < int'(cnt); k++) begin
            d = pick64();
            for (int j = w - 1; j >= 0; j--) bitq.push_back(d[j]);
        end
        while (bitq.size() % 8 != 0) bitq.push_back(1'b0);
        for (int i = 0; i < bitq.size(); i += 8) begin
            for (int j = 0; j < 8; j++) b[7-j] = bitq[i+j];
            if (noisy && $urandom_range(9) == 0) push_beat(K_DRAIN, 8'($urandom), 1'b0);
            push_beat(K_BYTE, b, 1'b1);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            beat_busy = 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                decode_beat(cur_beat.kind, s_axis_tdata);
                n_in_acc++;
                beat_busy = 1'b0;
            end
            if (!beat_busy && pending_beats.size() > 0 && pending_beats[0].hold
                    && expected_vals.size() == 0)
                void'(pending_beats.pop_front());
            if (!beat_busy && pending_beats.size() > 0 && !pending_beats[0].hold
                    && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                cur_beat = pending_beats.pop_front();
                beat_busy = 1'b1;
            end
            s_axis_tvalid <= beat_busy;
            s_axis_tdata  <= cur_beat.data;
            s_axis_tuser  <= cur_beat.kind;
        end
    end

    always @(posedge i_clk) begin
        t_dec_val e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_vals.size() == 0) begin
                    $error("unexpected result beat: value %h", m_axis_tdata);
                    n_fail++;
                end else begin
                    e = expected_vals.pop_front();
                    if (m_axis_tdata !== e.value) begin
                        $error("value: expected %h, got %h", e.value, m_axis_tdata);
                        n_fail++;
                    end
                    if (m_axis_tuser[USR_FIRST] !== e.blk_first) begin
                        $error("first_of_block: expected %b, got %b",
                               e.blk_first, m_axis_tuser[USR_FIRST]);
                        n_fail++;
                    end
                    if (m_axis_tuser[USR_LAST] !== e.blk_last) begin
                        $error("last_of_block: expected %b, got %b",
                               e.blk_last, m_axis_tuser[USR_LAST]);
                        n_fail++;
                    end
                    if (m_axis_tuser[USR_ERR] !== e.wid_err) begin
                        $error("width_error: expected %b, got %b",
                               e.wid_err, m_axis_tuser[USR_ERR]);
                        n_fail++;
                    end
                    if (m_axis_tlast !== e.beat_last) begin
                        $error("last_result: expected %b, got %b", e.beat_last, m_axis_tlast);
                        n_fail++;
                    end
                end
            end
            m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [31:0] cnt;
        logic [31:0] wraw;
        int          sel;
        ph = PH_HEADER;
        hcnt = '0;
        vals_left = '0;
        dw = 0;
        min_d = '0;
        run_val = '0;
        acc = '0;
        nbits = 0;
        hshift = '0;
        n_rand = 0;

        // directed
        push_beat(K_DRAIN, 8'h00, 1'b0);
        add_block(32'd0, 32'd5, 64'd1, 64'h8000_0000_0000_0000, 1'b0);
        add_block(32'hffff_ffff, 32'hffff_ffff, '1, '1, 1'b0);
        add_block(32'd9, 32'd1, '1, 64'h7fff_ffff_ffff_ffff, 1'b0);
        push_hold();
        add_block(32'd2, 32'd64, 64'h8000_0000_0000_0000, 64'd0, 1'b1);
        add_block(32'd3, 32'd0, 64'd5, '1, 1'b1);
        add_block(32'd1, 32'd65, 64'd7, 64'd9, 1'b0);

        // random blocks, topping up to the item budget
        while (n_rand < RAND_ITEMS) begin
            sel = $urandom_range(99);
            if (sel < 10) wraw = 0;
            else if (sel < 40) wraw = $urandom_range(1, 8);
            else if (sel < 75) wraw = $urandom_range(1, 64);
            else if (sel < 87) wraw = 64;
            else if (sel < 91) wraw = 65;
            else if (sel < 95) wraw = 32'hffff_ffff;
            else wraw = $urandom | 32'h80;
            if (wraw > MAX_WIDTH_DEF) cnt = $urandom;
            else if (wraw > 32) cnt = $urandom_range(0, 4);
            else cnt = $urandom_range(0, 10);
            add_block(cnt, wraw, pick64(), pick64(), $urandom_range(3) == 0);
            if ($urandom_range(5) == 0) push_hold();
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pending_beats.size() != 0 || beat_busy) @(posedge i_clk);
        while (expected_vals.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (n_fail == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
